/* rtl/core/fxd_pkg.sv */
// ----------------------------------------------------------------------------
// fxd_pkg - shared constants for the fixed-point to decimal text unit
// Character codes, register width and elaboration-time helpers.
// ----------------------------------------------------------------------------
package fxd_pkg;

	// register and output widths
	localparam int CFG_W   = 4;
	localparam int CHAR_W  = 8;
	localparam int MAX_OUT = 16;
	localparam int CNT_W   = 4;

	// default sizes of the number format
	localparam int DEF_FRAC_BITS       = 16;
	localparam int DEF_INT_BITS        = 16;
	localparam int DEF_MAX_FRAC_DIGITS = 9;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	// decimal digits needed for an unsigned number of the given bit count
	function automatic int dec_digits(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

	// index width over a number of digits, never below one bit
	function automatic int idx_width(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

/* rtl/core/fxd_front.sv */
// ----------------------------------------------------------------------------
// fxd_front - input side of the decimal text unit
// Takes a word, splits sign, integer and fraction, converts the integer part
// to BCD by shift-and-add-3 (one bit a cycle) and queues the result.
// ----------------------------------------------------------------------------
module fxd_front import fxd_pkg::*; #(
	parameter int FRAC_BITS       = DEF_FRAC_BITS,
	parameter int INT_BITS        = DEF_INT_BITS,
	parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
	parameter int INT_DIGITS      = dec_digits(INT_BITS),
	parameter int IDX_W           = idx_width(INT_DIGITS),
	parameter int ENT_W           = 1 + IDX_W + 4*INT_DIGITS + FRAC_BITS + CFG_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [INT_BITS+FRAC_BITS-1:0] in_value,
	input  logic                          cfg_wen,
	input  logic [CFG_W-1:0]              cfg_wdata,
	output logic                          q_push,
	output logic [ENT_W-1:0]              q_wdata,
	input  logic                          q_full
);

	localparam int VAL_W = INT_BITS + FRAC_BITS;
	localparam int STEP_W = $clog2(INT_BITS + 1);
	localparam int BCD_W = 4 * INT_DIGITS;

	logic                 busy_q;
	logic [STEP_W-1:0]    step_q;
	logic [INT_BITS-1:0]  shreg_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     bcd_adj;
	logic                 neg_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [CFG_W-1:0]     nd_q;
	logic [CFG_W-1:0]     frac_digits_q;
	logic [VAL_W-1:0]     mag;
	logic [IDX_W-1:0]     top_idx;
	logic                 conv_done;
	logic                 accept;

	assign in_ready  = !busy_q;
	assign accept    = in_valid && !busy_q;
	assign conv_done = (step_q == STEP_W'(INT_BITS));
	assign q_push    = busy_q && conv_done && !q_full;

	// magnitude: the most negative value comes out exact as 1 followed by zeros
	assign mag = in_value[VAL_W-1] ? (~in_value + VAL_W'(1)) : in_value;

	// add 3 to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < INT_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				(bcd_q[4*i +: 4] + 4'd3) : bcd_q[4*i +: 4];
		end
	end

	// position of the most significant non-zero digit (zero gives digit 0)
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < INT_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	assign q_wdata = {neg_q, top_idx, bcd_q, frac_q, nd_q};

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_digits_q <= '0;
		end else if (cfg_wen) begin
			frac_digits_q <= cfg_wdata;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q && !conv_done) begin
			step_q <= step_q + STEP_W'(1);
		end else if (q_push) begin
			busy_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= in_value[VAL_W-1];
			shreg_q <= mag[VAL_W-1:FRAC_BITS];
			frac_q  <= mag[FRAC_BITS-1:0];
			bcd_q   <= '0;
			nd_q    <= (frac_digits_q > CFG_W'(MAX_FRAC_DIGITS)) ?
				CFG_W'(MAX_FRAC_DIGITS) : frac_digits_q;
		end else if (busy_q && !conv_done) begin
			bcd_q   <= {bcd_adj[BCD_W-2:0], shreg_q[INT_BITS-1]};
			shreg_q <= shreg_q << 1;
		end
	end

endmodule

/* rtl/core/fxd_queue.sv */
// ----------------------------------------------------------------------------
// fxd_queue - two-entry queue between front and back
// Lets the front convert the next word while the back still prints.
// ----------------------------------------------------------------------------
module fxd_queue import fxd_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] ent_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* rtl/core/fxd_back.sv */
// ----------------------------------------------------------------------------
// fxd_back - output side of the decimal text unit
// Sequencer that prints sign, integer digits, point and fraction digits,
// one character a cycle unless stalled, into a registered output word.
// ----------------------------------------------------------------------------
module fxd_back import fxd_pkg::*; #(
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int INT_DIGITS = dec_digits(DEF_INT_BITS),
	parameter int IDX_W      = idx_width(INT_DIGITS),
	parameter int ENT_W      = 1 + IDX_W + 4*INT_DIGITS + FRAC_BITS + CFG_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  logic [ENT_W-1:0]  q_rdata,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              out_last
);

	localparam int BCD_W = 4 * INT_DIGITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SIGN  = 3'd1;
	localparam logic [2:0] ST_INT   = 3'd2;
	localparam logic [2:0] ST_POINT = 3'd3;
	localparam logic [2:0] ST_FRAC  = 3'd4;

	logic [2:0]           state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [CFG_W-1:0]     nd_q;
	logic [CFG_W-1:0]     fcnt_q;
	logic [CNT_W-1:0]     ccount_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_last_q;

	logic                 e_neg;
	logic [IDX_W-1:0]     e_idx;
	logic [BCD_W-1:0]     e_bcd;
	logic [FRAC_BITS-1:0] e_frac;
	logic [CFG_W-1:0]     e_nd;

	logic                 out_free;
	logic                 emit;
	logic [CHAR_W-1:0]    ch;
	logic                 last_nat;
	logic                 last;
	logic [FRAC_BITS+3:0] prod;

	assign {e_neg, e_idx, e_bcd, e_frac, e_nd} = q_rdata;

	assign out_free  = !out_valid_q || out_ready;
	assign emit      = (state_q != ST_IDLE) && out_free;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	// next fraction digit: times ten, the digit falls out above the binary point
	assign prod = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};

	// character and end-of-text flag for the current step
	always_comb begin
		case (state_q)
			ST_SIGN: begin
				ch       = CH_MINUS;
				last_nat = 1'b0;
			end
			ST_INT: begin
				ch       = CH_ZERO + {4'd0, bcd_q[idx_q*4 +: 4]};
				last_nat = (idx_q == '0) && (nd_q == '0);
			end
			ST_POINT: begin
				ch       = CH_POINT;
				last_nat = 1'b0;
			end
			ST_FRAC: begin
				ch       = CH_ZERO + {4'd0, prod[FRAC_BITS +: 4]};
				last_nat = (fcnt_q == CFG_W'(1));
			end
			default: begin
				ch       = CH_ZERO;
				last_nat = 1'b0;
			end
		endcase
	end

	// text is cut after the sixteenth character
	assign last = last_nat || (ccount_q == CNT_W'(MAX_OUT - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ccount_q <= '0;
		end else if (q_pop) begin
			state_q  <= e_neg ? ST_SIGN : ST_INT;
			ccount_q <= '0;
		end else if (emit) begin
			ccount_q <= ccount_q + CNT_W'(1);
			if (last) begin
				state_q <= ST_IDLE;
			end else begin
				case (state_q)
					ST_SIGN:  state_q <= ST_INT;
					ST_INT:   state_q <= (idx_q == '0) ? ST_POINT : ST_INT;
					ST_POINT: state_q <= ST_FRAC;
					default:  state_q <= state_q;
				endcase
			end
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			idx_q  <= e_idx;
			bcd_q  <= e_bcd;
			frac_q <= e_frac;
			nd_q   <= e_nd;
		end else if (emit) begin
			case (state_q)
				ST_INT: begin
					if (idx_q != '0) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				ST_POINT: begin
					fcnt_q <= nd_q;
				end
				ST_FRAC: begin
					frac_q <= prod[FRAC_BITS-1:0];
					fcnt_q <= fcnt_q - CFG_W'(1);
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= ch;
			out_last_q <= last;
		end
	end

endmodule

/* rtl/core/fixed_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_unit - signed fixed-point to decimal ASCII text
//
//   channel   dir  handshake                 contents
//   s_axis    in   s_tvalid / s_tready        tdata: value
//   m_axis    out  m_tvalid / m_tready        tdata: char_code, tlast: last_char
//   config    in   cfg_wen                    cfg_wdata: frac_digits
//
// The front converts one BCD bit a cycle in the shift-and-add-3 converter,
// then pushes to the queue and only then takes the next word; the back loads
// an entry and prints one character a cycle while m_tready does not stall it.
// The default format is Q16.16.
// Reset clears control state and frac_digits; no clearing pass is needed.
// A stalled m_tready holds the back; the two-entry queue keeps the front going.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_unit import fxd_pkg::*; #(
	parameter int FRAC_BITS       = DEF_FRAC_BITS,
	parameter int INT_BITS        = DEF_INT_BITS,
	parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
	parameter int TDATA_W         = ((INT_BITS + FRAC_BITS + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [CHAR_W-1:0]  m_tdata,   // char_code
	output logic               m_tlast,   // last_char
	input  logic               cfg_wen,
	input  logic [CFG_W-1:0]   cfg_wdata  // frac_digits
);

	localparam int VAL_W      = INT_BITS + FRAC_BITS;
	localparam int INT_DIGITS = dec_digits(INT_BITS);
	localparam int IDX_W      = idx_width(INT_DIGITS);
	localparam int ENT_W      = 1 + IDX_W + 4*INT_DIGITS + FRAC_BITS + CFG_W;

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	logic [ENT_W-1:0] q_wdata;
	logic [ENT_W-1:0] q_rdata;

	fxd_front #(
		.FRAC_BITS       (FRAC_BITS),
		.INT_BITS        (INT_BITS),
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
		.INT_DIGITS      (INT_DIGITS),
		.IDX_W           (IDX_W),
		.ENT_W           (ENT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata[VAL_W-1:0]),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_push    (q_push),
		.q_wdata   (q_wdata),
		.q_full    (q_full)
	);

	fxd_queue #(
		.W (ENT_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	fxd_back #(
		.FRAC_BITS  (FRAC_BITS),
		.INT_DIGITS (INT_DIGITS),
		.IDX_W      (IDX_W),
		.ENT_W      (ENT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

/* rtl/core/fxd_checker.sv */
// ----------------------------------------------------------------------------
// fxd_checker - port-level checks for the decimal text unit
// Watches the top level's ports and is bound to it below.
// ----------------------------------------------------------------------------
module fxd_checker import fxd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [CHAR_W-1:0] m_tdata,
	input logic              m_tlast
);

	// a stalled output word holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// only sign, point and decimal digits are printed
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == CH_MINUS) || (m_tdata == CH_POINT) ||
			((m_tdata >= CH_ZERO) && (m_tdata <= CH_ZERO + 8'd9)))
		else $error("character outside the decimal set");

	// a sign is always followed by a digit, so never ends the text
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == CH_MINUS) |-> !m_tlast)
		else $error("sign marked as last character");

	// the converter is not ready again in the cycle after taking a word
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready straight after a word was taken");

endmodule

bind fixed_to_decimal_ascii_unit fxd_checker u_fxd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* tb/fxd_text_scoreboard.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fxd_text_scoreboard - text predictor and checker for the decimal text unit
// Watches the input, output and register ports. Each accepted value is turned
// into its expected decimal characters, and each character the unit sends is
// compared against the oldest one waiting.
// ----------------------------------------------------------------------------
module fxd_text_scoreboard import fxd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [31:0]       s_tdata,    // value
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [CHAR_W-1:0] m_tdata,    // char_code
	input  logic              m_tlast,    // last_char
	input  logic              cfg_wen,
	input  logic [CFG_W-1:0]  cfg_wdata,  // frac_digits
	output int                errors,
	output int                pending
);

	localparam int FB    = DEF_FRAC_BITS;
	localparam int VAL_W = DEF_INT_BITS + DEF_FRAC_BITS;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	text_char_t       expected_chars[$];
	logic [CFG_W-1:0] frac_digits;
	int               char_seen;

	initial begin
		errors    = 0;
		pending   = 0;
		char_seen = 0;
	end

	// build the decimal text of one value and queue it, last flag included
	function automatic void queue_decimal_text(logic [VAL_W-1:0] value, logic [CFG_W-1:0] fd);
		logic              neg;
		logic [63:0]       mag;
		logic [63:0]       ipart;
		logic [63:0]       scaled;
		logic [63:0]       scale;
		logic [CHAR_W-1:0] text[$];
		logic [CHAR_W-1:0] digs[$];
		int                nd;
		int                len;
		text_char_t        c;

		neg = value[VAL_W-1];
		mag = neg ? ((64'd1 << VAL_W) - {32'd0, value}) : {32'd0, value};
		ipart = mag >> FB;
		nd = (fd > DEF_MAX_FRAC_DIGITS) ? DEF_MAX_FRAC_DIGITS : int'(fd);

		if (neg)
			text.push_back(CH_MINUS);

		// integer part, a zero part still gives one digit
		do begin
			digs.push_front(CH_ZERO + CHAR_W'(ipart % 10));
			ipart = ipart / 10;
		end while (ipart != 0);
		foreach (digs[i])
			text.push_back(digs[i]);

		// truncated fraction, padded to exactly nd digits
		if (nd != 0) begin
			scale = 64'd1;
			for (int k = 0; k < nd; k++)
				scale = scale * 10;
			scaled = ((mag & ((64'd1 << FB) - 1)) * scale) >> FB;
			text.push_back(CH_POINT);
			digs.delete();
			for (int k = 0; k < nd; k++) begin
				digs.push_front(CH_ZERO + CHAR_W'(scaled % 10));
				scaled = scaled / 10;
			end
			foreach (digs[i])
				text.push_back(digs[i]);
		end

		len = (text.size() > MAX_OUT) ? MAX_OUT : text.size();
		for (int k = 0; k < len; k++) begin
			c.code = text[k];
			c.last = (k == len - 1);
			expected_chars.push_back(c);
		end
	endfunction

	// sample every channel at the rising edge
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			expected_chars.delete();
			frac_digits = '0;
		end else begin
			if (cfg_wen)
				frac_digits = cfg_wdata;
			if (s_tvalid && s_tready)
				queue_decimal_text(s_tdata, frac_digits);
			if (m_tvalid && m_tready) begin
				char_seen++;
				if (expected_chars.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("[%0t] char %0d: unexpected word, code %h last %b",
							$realtime, char_seen, m_tdata, m_tlast);
				end else begin
					want = expected_chars.pop_front();
					if (want.code !== m_tdata || want.last !== m_tlast) begin
						errors++;
						if (errors <= 10)
							$display("[%0t] char %0d: expected code %h last %b, got code %h last %b",
								$realtime, char_seen, want.code, want.last, m_tdata, m_tlast);
					end
				end
			end
		end
		pending = expected_chars.size();
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for the fixed-point to decimal text unit
// Feeds directed corner values and random Q16.16 values under several
// digit-count settings and idle patterns, including a long output stall,
// while the scoreboard checks every character that comes out.
// ----------------------------------------------------------------------------
module tb;
	import fxd_pkg::*;

	localparam int HOLD_LEN = 300;
	localparam int SETTLE   = 40;
	localparam int SEG_LEN  = 25;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [CHAR_W-1:0] m_tdata;
	logic              m_tlast;
	logic              cfg_wen   = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	int errors;
	int pending;
	int src_idle  = 11;
	int sink_idle = 49;
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// corner values: zero, extremes, the smallest steps, whole and half units
	logic [31:0] corner_vals[12] = '{
		32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
		32'h0000_FFFF, 32'h1234_5678, 32'hFFFE_8000, 32'h7FFF_0000
	};
	logic [CFG_W-1:0] seg_digits[9] = '{4'd1, 4'd9, 4'd0, 4'd15, 4'd4, 4'd10, 4'd7, 4'd2, 4'd9};

	always #5 clk = ~clk;

	fixed_to_decimal_ascii_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	fxd_text_scoreboard u_scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	// output side: random back-pressure, or a long counted hold on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle);
		end
	end

	// offer one word, with random idle cycles ahead of it; starts and ends at a falling edge
	task automatic send_word(input logic [31:0] v);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop offering and wait until every character has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// register write, only once the unit has gone quiet
	task automatic write_frac_digits(input logic [CFG_W-1:0] v);
		drain();
		repeat (SETTLE) @(negedge clk);
		cfg_wdata <= v;
		cfg_wen   <= 1'b1;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: begin
				v = {16'($urandom_range(0, 99)), 16'($urandom)};
				if ($urandom_range(1))
					v = -v;
			end
			2: v = {($urandom_range(1) ? 16'hFFFF : 16'h0000), 16'($urandom)};
			default: begin
				case ($urandom_range(4))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h0000_0001;
					default: v = 32'h8000_0001;
				endcase
			end
		endcase
		return v;
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset setting prints no point
		for (int i = 0; i < 6; i++)
			send_word(corner_vals[i]);
		write_frac_digits(4'd9);
		foreach (corner_vals[i])
			send_word(corner_vals[i]);
		// digit counts above the maximum saturate
		write_frac_digits(4'd15);
		for (int i = 0; i < 4; i++)
			send_word(corner_vals[i + 1]);

		// random part, three idle patterns over nine digit settings
		for (int seg = 0; seg < 9; seg++) begin
			write_frac_digits(seg_digits[seg]);
			if (seg < 3) begin
				src_idle  = 11;
				sink_idle = 49;
			end else if (seg < 6) begin
				src_idle  = 49;
				sink_idle = 11;
			end else begin
				src_idle  = 0;
				sink_idle = 0;
			end
			for (int i = 0; i < SEG_LEN; i++) begin
				if (seg == 4 && i == 4) begin
					// long output stall while words keep coming: input must back up
					src_idle = 0;
					hold_req++;
				end
				if (seg == 1 && i == SEG_LEN / 2)
					drain();
				send_word(pick_value());
			end
		end

		drain();
		repeat (SETTLE) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("fixed_to_decimal_ascii_unit: match");
		else
			$display("fixed_to_decimal_ascii_unit: mismatch");
		$finish;
	end

	initial begin
		#5ms;
		$display("fixed_to_decimal_ascii_unit: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/fxd_pkg.sv
rtl/core/fxd_front.sv
rtl/core/fxd_queue.sv
rtl/core/fxd_back.sv
rtl/core/fixed_to_decimal_ascii_unit.sv
rtl/core/fxd_checker.sv
tb/fxd_text_scoreboard.sv
tb/tb.sv
